FILE: hdl/page_frame_free_list_allocator_assert.svh
// ----------------------------------------------------------------------------
// Page frame allocator assertion macros
// Concurrent checks clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAME_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define PAGE_FRAME_FREE_LIST_ALLOCATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define PFFLA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pffla assertion failed");
// next-cycle implication
`define PFFLA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pffla assertion failed");
`else
`define PFFLA_ASSERT_NOW(label, ante, cons)
`define PFFLA_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: hdl/pffla_pkg.sv
// ----------------------------------------------------------------------------
// Page frame allocator package
// Field widths, status codes and the job word passed from front to back.
// ----------------------------------------------------------------------------
package pffla_pkg;

	localparam int FIELD_W     = 7;   // page index / count field width
	localparam int PAGE_SHIFT  = 21;  // 2 MiB pages
	localparam int ADDR_W      = FIELD_W + PAGE_SHIFT;
	localparam int QUEUE_DEPTH = 2;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_GRANTED = 2'd0,
		ST_NONE    = 2'd1,
		ST_REJECT  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		OP_ALLOC  = 2'd0,
		OP_FREE   = 2'd1,
		OP_REJECT = 2'd2
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [FIELD_W-1:0] count;  // clamped request size
		logic [FIELD_W-1:0] index;  // page being freed
	} job_t;

endpackage

FILE: hdl/pffla_if.sv
// ----------------------------------------------------------------------------
// Page frame allocator channels
// Request and response valid/ready bundles.
// ----------------------------------------------------------------------------
interface pffla_in_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [6:0] page_count;
	logic [6:0] free_index;

	modport source (output valid, output cmd, output page_count, output free_index,
		input ready);
	modport sink (input valid, input cmd, input page_count, input free_index,
		output ready);
endinterface

interface pffla_out_if;
	logic        valid;
	logic        ready;
	logic [6:0]  page_number;
	logic [27:0] page_address;
	logic        last;
	logic [1:0]  status;

	modport source (output valid, output page_number, output page_address, output last,
		output status, input ready);
	modport sink (input valid, input page_number, input page_address, input last,
		input status, output ready);
endinterface

FILE: hdl/pffla_front.sv
// ----------------------------------------------------------------------------
// Page frame allocator front end
// Takes request words, clamps the batch size, screens bad free indices.
// ----------------------------------------------------------------------------
module pffla_front #(
	parameter int NUM_PAGES = 128,
	parameter int MAX_BATCH = 64
) (
	pffla_in_if.sink          req,
	input  logic              room,
	output logic              push,
	output pffla_pkg::job_t   job
);
	import pffla_pkg::*;

	assign req.ready = room;
	assign push      = req.valid && room;

	always_comb begin
		job.index = req.free_index;
		if (32'(req.page_count) > MAX_BATCH) begin
			job.count = FIELD_W'(MAX_BATCH);
		end else begin
			job.count = req.page_count;
		end
		if (req.cmd == CMD_ALLOC) begin
			job.op = OP_ALLOC;
		end else if (32'(req.free_index) >= NUM_PAGES) begin
			job.op = OP_REJECT;
		end else begin
			job.op = OP_FREE;
		end
	end

endmodule

FILE: hdl/pffla_queue.sv
// ----------------------------------------------------------------------------
// Page frame allocator job queue
// Small FIFO decoupling the front end from the stack engine.
// ----------------------------------------------------------------------------
module pffla_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  pffla_pkg::job_t wr_job,
	output logic            room,
	input  logic            pop,
	output logic            head_valid,
	output pffla_pkg::job_t head
);
	import pffla_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FILL_MAX = CNT_W'(QUEUE_DEPTH);

	job_t             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] fill_q;
	logic             do_wr, do_rd;

	assign room       = fill_q != FILL_MAX;
	assign head_valid = fill_q != '0;
	assign head       = slot_q[rd_ptr_q];
	assign do_wr      = push && room;
	assign do_rd      = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				fill_q <= fill_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				fill_q <= fill_q - CNT_W'(1);
			end
		end
	end

endmodule

FILE: hdl/pffla_back.sv
// ----------------------------------------------------------------------------
// Page frame allocator stack engine
// Free-list stack memory, one push or pop per cycle unless rsp stalls, response register.
// ----------------------------------------------------------------------------
`include "page_frame_free_list_allocator_assert.svh"

module pffla_back #(
	parameter int NUM_PAGES = 128
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  pffla_pkg::job_t head,
	output logic            deq,
	pffla_out_if.source     rsp
);
	import pffla_pkg::*;

	localparam int AW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
	localparam int CW = $clog2(NUM_PAGES + 1);
	localparam int PW = (AW > FIELD_W) ? AW : FIELD_W;
	localparam logic [CW-1:0] FULL = CW'(NUM_PAGES);

	// stack memory; entries below the low-water mark still hold reset contents
	logic [AW-1:0] mem [NUM_PAGES];

	logic [CW-1:0]      count_q, min_q;
	logic [FIELD_W-1:0] n_q;          // pops done for the head job
	logic [AW-1:0]      rd_q;

	logic               out_valid_q, use_mem_q, last_q;
	status_t            st_q;
	logic [PW-1:0]      page_q;

	logic               slot_free, issue, do_pop, do_push, emit;
	logic               e_last, e_mem, last_pop;
	status_t            e_st;
	logic [PW-1:0]      e_page, idx_ext, page_sel;
	logic [AW-1:0]      top_addr;

	assign slot_free = !out_valid_q || rsp.ready;
	assign issue     = head_valid && slot_free;
	assign top_addr  = AW'(count_q - CW'(1));
	assign idx_ext   = PW'(head.index);
	assign last_pop  = ((n_q + FIELD_W'(1)) == head.count) || (count_q == CW'(1));

	always_comb begin
		do_pop  = 1'b0;
		do_push = 1'b0;
		emit    = 1'b0;
		deq     = 1'b0;
		e_last  = 1'b1;
		e_mem   = 1'b0;
		e_st    = ST_GRANTED;
		e_page  = '0;
		if (issue) begin
			unique case (head.op)
				OP_ALLOC: begin
					emit = 1'b1;
					if (n_q == '0 && (count_q == '0 || head.count == '0)) begin
						e_st = ST_NONE;
						deq  = 1'b1;
					end else begin
						do_pop = 1'b1;
						e_mem  = count_q != min_q;
						e_page = PW'(FULL - count_q);  // reset contents of top entry
						e_last = last_pop;
						deq    = last_pop;
					end
				end
				OP_FREE: begin
					deq = 1'b1;
					if (count_q == FULL) begin
						emit   = 1'b1;
						e_st   = ST_REJECT;
						e_page = idx_ext;
					end else begin
						do_push = 1'b1;
					end
				end
				OP_REJECT: begin
					deq    = 1'b1;
					emit   = 1'b1;
					e_st   = ST_REJECT;
					e_page = idx_ext;
				end
				default: begin
					deq = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[count_q[AW-1:0]] <= idx_ext[AW-1:0];
		end
		if (do_pop) begin
			rd_q <= mem[top_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= FULL;
			min_q       <= FULL;
			n_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_pop) begin
				count_q <= count_q - CW'(1);
				if (count_q == min_q) begin
					min_q <= count_q - CW'(1);
				end
				n_q <= deq ? '0 : n_q + FIELD_W'(1);
			end
			if (do_push) begin
				count_q <= count_q + CW'(1);
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			use_mem_q <= e_mem;
			page_q    <= e_page;
			last_q    <= e_last;
			st_q      <= e_st;
		end
	end

	assign page_sel         = use_mem_q ? PW'(rd_q) : page_q;
	assign rsp.valid        = out_valid_q;
	assign rsp.page_number  = page_sel[FIELD_W-1:0];
	assign rsp.page_address = (st_q == ST_GRANTED) ?
		{page_sel[FIELD_W-1:0], {PAGE_SHIFT{1'b0}}} : {ADDR_W{1'b0}};
	assign rsp.last         = last_q;
	assign rsp.status       = st_q;

	`PFFLA_ASSERT_NOW(a_count_bound, 1'b1, count_q <= FULL)
	`PFFLA_ASSERT_NOW(a_low_water, 1'b1, min_q <= count_q)
	`PFFLA_ASSERT_NEXT(a_pop_shows, do_pop, out_valid_q)
	`PFFLA_ASSERT_NOW(a_batch_open, n_q != '0,
		head_valid && head.op == OP_ALLOC && n_q < head.count)

endmodule

FILE: hdl/page_frame_free_list_allocator.sv
// ----------------------------------------------------------------------------
// Page frame free list allocator
// LIFO free list of 2 MiB page frames with batch allocate and single free.
// ----------------------------------------------------------------------------
//  channel | dir | words
//  --------+-----+--------------------------------------------------------
//  req     | in  | cmd, page_count, free_index
//  rsp     | out | page_number, page_address, last, status
//
//  One stack push or pop per cycle while rsp is not stalled: an allocate of n
//  pages pops once per granted page, any other request takes a single step.
//  Each response is held in the response register behind the job queue.
//  After reset the stack is full with page 0 on top; no clearing pass runs,
//  a low-water mark tells which entries still hold their reset contents.
//  A stalled rsp holds its word; requests queue two deep behind it.
// ----------------------------------------------------------------------------
module page_frame_free_list_allocator #(
	parameter int NUM_PAGES = 128,
	parameter int MAX_BATCH = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	pffla_in_if.sink     req,
	pffla_out_if.source  rsp
);
	import pffla_pkg::*;

	logic push, room, head_valid, deq;
	job_t wr_job, head;

	// front: clamp batch, flag out-of-range free
	pffla_front #(
		.NUM_PAGES(NUM_PAGES),
		.MAX_BATCH(MAX_BATCH)
	) u_front (
		.req (req),
		.room(room),
		.push(push),
		.job (wr_job)
	);

	// two-deep job queue
	pffla_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_job    (wr_job),
		.room      (room),
		.pop       (deq),
		.head_valid(head_valid),
		.head      (head)
	);

	// back: stack memory and response register
	pffla_back #(
		.NUM_PAGES(NUM_PAGES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head      (head),
		.deq       (deq),
		.rsp       (rsp)
	);

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// Page frame allocator testbench
// Drives allocate and free words into the request channel and checks every
// response word against a LIFO free-list predictor kept in the testbench.
// A table of directed words comes first, then randomized traffic.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pffla_pkg::*;

	localparam int NUM_PAGES    = 128;
	localparam int MAX_BATCH    = 64;
	localparam int CLK_PERIOD   = 8;
	localparam int RESET_CYCLES = 9;
	localparam int RANDOM_ITEMS = 400;
	localparam int TAIL_ITEMS   = 60;    // last stretch runs with no idling
	localparam int PRESSURE_AT  = 160;   // random item at which the long hold-off starts
	localparam int HOLD_CYCLES  = 400;   // length of that hold-off
	localparam int DRAIN_CYCLES = 10;    // padding after the last expected word
	localparam int MAX_REPORTS  = 10;
	// Slowest plausible run: every item yielding 64 words, each waiting out the
	// longest stall, plus gaps and the hold-off; taken several times over.
	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam int NUM_DIRECTED = 23;

	// One response word as the checker sees it.
	typedef struct packed {
		logic [FIELD_W-1:0] page_number;
		logic [ADDR_W-1:0]  page_address;
		logic               last;
		status_t            status;
	} rsp_word_t;

	// One row of the directed table. Where typed is set, the row also gives
	// the number of words and the first word, read straight off the spec.
	typedef struct packed {
		logic               cmd;
		logic [FIELD_W-1:0] count;
		logic [FIELD_W-1:0] index;
		logic               typed;
		logic [FIELD_W-1:0] n_words;
		logic [FIELD_W-1:0] exp_page;
		logic [ADDR_W-1:0]  exp_addr;
		logic               exp_last;
		status_t            exp_status;
	} stim_row_t;

	// Starting from reset: page 0 on top, all 128 pages free.
	stim_row_t directed_rows [NUM_DIRECTED] = '{
		// free onto a full stack is rejected and echoes the index
		'{CMD_FREE,  7'd0,   7'd5,   1'b1, 7'd1,  7'd5,   28'h0000000, 1'b1, ST_REJECT},
		'{CMD_FREE,  7'd0,   7'd127, 1'b1, 7'd1,  7'd127, 28'h0000000, 1'b1, ST_REJECT},
		// zero count grants nothing
		'{CMD_ALLOC, 7'd0,   7'd0,   1'b1, 7'd1,  7'd0,   28'h0000000, 1'b1, ST_NONE},
		// single page from the top, then a short batch
		'{CMD_ALLOC, 7'd1,   7'd0,   1'b1, 7'd1,  7'd0,   28'h0000000, 1'b1, ST_GRANTED},
		'{CMD_ALLOC, 7'd3,   7'd0,   1'b1, 7'd3,  7'd1,   28'h0200000, 1'b0, ST_GRANTED},
		// double free of page 127 is not caught: it goes on top
		'{CMD_FREE,  7'd0,   7'd127, 1'b1, 7'd0,  7'd0,   28'h0000000, 1'b0, ST_GRANTED},
		'{CMD_ALLOC, 7'd1,   7'd0,   1'b1, 7'd1,  7'd127, 28'hFE00000, 1'b1, ST_GRANTED},
		// oversized request clamps to the batch limit
		'{CMD_ALLOC, 7'd127, 7'd0,   1'b1, 7'd64, 7'd4,   28'h0800000, 1'b0, ST_GRANTED},
		// short supply: 60 pages left
		'{CMD_ALLOC, 7'd64,  7'd0,   1'b1, 7'd60, 7'd68,  28'h8800000, 1'b0, ST_GRANTED},
		// empty stack
		'{CMD_ALLOC, 7'd5,   7'd0,   1'b1, 7'd1,  7'd0,   28'h0000000, 1'b1, ST_NONE},
		'{CMD_FREE,  7'd0,   7'd0,   1'b1, 7'd0,  7'd0,   28'h0000000, 1'b0, ST_GRANTED},
		'{CMD_FREE,  7'd0,   7'd126, 1'b0, 7'd0,  7'd0,   28'h0000000, 1'b0, ST_GRANTED},
		'{CMD_FREE,  7'd0,   7'd85,  1'b0, 7'd0,  7'd0,   28'h0000000, 1'b0, ST_GRANTED},
		'{CMD_FREE,  7'd0,   7'd42,  1'b0, 7'd0,  7'd0,   28'h0000000, 1'b0, ST_GRANTED},
		'{CMD_ALLOC, 7'd2,   7'd0,   1'b0, 7'd0,  7'd0,   28'h0000000, 1'b0, ST_GRANTED},
		// just above the batch limit, also short; index field ignored
		'{CMD_ALLOC, 7'd65,  7'd127, 1'b0, 7'd0,  7'd0,   28'h0000000, 1'b0, ST_GRANTED},
		// count field ignored on a free
		'{CMD_FREE,  7'd127, 7'd64,  1'b0, 7'd0,  7'd0,   28'h0000000, 1'b0, ST_GRANTED},
		'{CMD_FREE,  7'd0,   7'd1,   1'b0, 7'd0,  7'd0,   28'h0000000, 1'b0, ST_GRANTED},
		'{CMD_ALLOC, 7'd64,  7'd0,   1'b0, 7'd0,  7'd0,   28'h0000000, 1'b0, ST_GRANTED},
		'{CMD_ALLOC, 7'd1,   7'd0,   1'b1, 7'd1,  7'd0,   28'h0000000, 1'b1, ST_NONE},
		'{CMD_FREE,  7'd0,   7'd3,   1'b0, 7'd0,  7'd0,   28'h0000000, 1'b0, ST_GRANTED},
		'{CMD_FREE,  7'd0,   7'd7,   1'b0, 7'd0,  7'd0,   28'h0000000, 1'b0, ST_GRANTED},
		'{CMD_ALLOC, 7'd2,   7'd0,   1'b0, 7'd0,  7'd0,   28'h0000000, 1'b0, ST_GRANTED}
	};

	logic clk = 1'b0;
	logic arst_n;

	pffla_in_if  req_if ();
	pffla_out_if rsp_if ();

	page_frame_free_list_allocator #(
		.NUM_PAGES(NUM_PAGES),
		.MAX_BATCH(MAX_BATCH)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_if),
		.rsp   (rsp_if)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ------------------------------------------------------------------
	// Free-list predictor: the stack, its depth, and the words it expects.
	// held_pages tracks what is currently handed out, so random frees can
	// mostly return real allocations.
	// ------------------------------------------------------------------
	logic [FIELD_W-1:0] free_pages [NUM_PAGES];
	int                 free_total;
	rsp_word_t          pending_words [$];
	logic [FIELD_W-1:0] held_pages [$];

	// Stimulus control; quiet_tail and hold_pending are shared with the receiver process.
	bit quiet_tail   = 1'b0;
	bit hold_pending = 1'b0;
	int idle_pct     = 20;

	// Bookkeeping.
	int fail_count   = 0;
	int words_seen   = 0;
	int alloc_seen   = 0;
	int free_seen    = 0;
	int none_seen    = 0;
	int reject_seen  = 0;
	int holds_done   = 0;
	int cycle_count  = 0;

	// Updates the predicted stack for one accepted request word and queues the
	// words it must produce. Returns how many; first_word is the first of them.
	function automatic int apply_request(input logic cmd, input logic [FIELD_W-1:0] count,
			input logic [FIELD_W-1:0] index, output rsp_word_t first_word);
		int                 want;
		int                 granted;
		int                 k;
		logic [FIELD_W-1:0] page;
		rsp_word_t          w;
		granted    = 0;
		first_word = '0;
		if (cmd == CMD_ALLOC) begin
			alloc_seen++;
			want = (int'(count) > MAX_BATCH) ? MAX_BATCH : int'(count);
			// pop in LIFO order until the request or the stack runs out
			while (granted < want && free_total > 0) begin
				free_total--;
				page = free_pages[free_total];
				w = '{page_number: page, page_address: {page, {PAGE_SHIFT{1'b0}}},
					last: 1'b0, status: ST_GRANTED};
				pending_words.push_back(w);
				held_pages.push_back(page);
				if (granted == 0)
					first_word = w;
				granted++;
			end
			if (granted == 0) begin
				// zero count or empty stack: one word, nothing granted
				w = '{page_number: '0, page_address: '0, last: 1'b1, status: ST_NONE};
				pending_words.push_back(w);
				first_word = w;
				none_seen++;
				return 1;
			end
			pending_words[pending_words.size() - 1].last = 1'b1;
			if (granted == 1)
				first_word.last = 1'b1;
			return granted;
		end
		free_seen++;
		if (free_total >= NUM_PAGES || int'(index) >= NUM_PAGES) begin
			// full stack (or out-of-range index): rejected, index echoed
			w = '{page_number: index, page_address: '0, last: 1'b1, status: ST_REJECT};
			pending_words.push_back(w);
			first_word = w;
			reject_seen++;
			return 1;
		end
		// accepted free: silent push, double frees included
		free_pages[free_total] = index;
		free_total++;
		for (k = 0; k < held_pages.size(); k++) begin
			if (held_pages[k] == index) begin
				held_pages.delete(k);
				break;
			end
		end
		return 0;
	endfunction

	task automatic note_failure(input string what, input rsp_word_t want, input rsp_word_t got);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("[%0t] %s: expected page %0d addr %h last %b status %s, got page %0d addr %h last %b status %s",
				$realtime, what, want.page_number, want.page_address, want.last, want.status.name(),
				got.page_number, got.page_address, got.last, got.status.name());
	endtask

	// Sends one request word: optional idle burst, then hold valid until the
	// block takes it. Predicts at the accepting edge.
	task automatic send_word(input logic cmd, input logic [FIELD_W-1:0] count,
			input logic [FIELD_W-1:0] index, output int n_words, output rsp_word_t first_word);
		int gap;
		gap = 0;
		if (!quiet_tail && $urandom_range(0, 99) < idle_pct)
			gap = $urandom_range(1, 18);
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid      <= 1'b1;
		req_if.cmd        <= cmd;
		req_if.page_count <= count;
		req_if.free_index <= index;
		// ready is read before the edge's updates land, i.e. as the DUT saw it
		do @(posedge clk); while (!req_if.ready);
		n_words = apply_request(cmd, count, index, first_word);
	endtask

	// ------------------------------------------------------------------
	// Response checker: every accepted word against the oldest expectation.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		rsp_word_t got;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			got = '{page_number: rsp_if.page_number, page_address: rsp_if.page_address,
				last: rsp_if.last, status: status_t'(rsp_if.status)};
			words_seen++;
			if (pending_words.size() == 0)
				note_failure("word with nothing expected", got, got);
			else if (pending_words[0] !== got) begin
				note_failure("response mismatch", pending_words[0], got);
				void'(pending_words.pop_front());
			end else
				void'(pending_words.pop_front());
		end
	end

	// ------------------------------------------------------------------
	// Receiver: stall bursts whose density changes from stretch to stretch,
	// one long hold-off on request, and no stalls in the tail.
	// ------------------------------------------------------------------
	initial begin
		int stall_pct;
		int span;
		int c;
		stall_pct = 0;
		span      = 0;
		rsp_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (span == 0) begin
				case ($urandom_range(0, 3))
					0, 1: stall_pct = 0;
					2:    stall_pct = 8;
					default: stall_pct = 25;
				endcase
				span = $urandom_range(40, 120);
			end
			span--;
			if (hold_pending) begin
				// long hold-off: the block's queue fills and req.ready drops
				hold_pending = 1'b0;
				rsp_if.ready <= 1'b0;
				for (c = 0; c < HOLD_CYCLES; c++)
					@(posedge clk);
				rsp_if.ready <= 1'b1;
				holds_done++;
			end else if (!quiet_tail && $urandom_range(0, 99) < stall_pct) begin
				rsp_if.ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
				rsp_if.ready <= 1'b1;
			end else begin
				rsp_if.ready <= 1'b1;
			end
		end
	end

	// Watchdog.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d words still expected",
			cycle_count, pending_words.size());
		$display("*** FAILED ***");
		$finish;
	end

	// ------------------------------------------------------------------
	// Main sequence: reset, directed table, random traffic, drain, verdict.
	// ------------------------------------------------------------------
	initial begin
		int         r;
		int         i;
		int         k;
		int         n_words;
		int         free_pct;
		int         pick;
		logic       cmd;
		logic [6:0] count;
		logic [6:0] index;
		rsp_word_t  first_word;
		rsp_word_t  typed_word;

		arst_n            <= 1'b0;
		req_if.valid      <= 1'b0;
		req_if.cmd        <= CMD_ALLOC;
		req_if.page_count <= '0;
		req_if.free_index <= '0;

		// reset image: entry k holds 127-k, so page 0 sits on top
		for (k = 0; k < NUM_PAGES; k++)
			free_pages[k] = FIELD_W'(NUM_PAGES - 1 - k);
		free_total = NUM_PAGES;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table. Typed rows cross-check the predictor's own output
		// against values taken from the spec; the DUT is always checked
		// against the predictor.
		for (r = 0; r < NUM_DIRECTED; r++) begin
			send_word(directed_rows[r].cmd, directed_rows[r].count, directed_rows[r].index,
				n_words, first_word);
			if (directed_rows[r].typed) begin
				typed_word = '{page_number: directed_rows[r].exp_page,
					page_address: directed_rows[r].exp_addr,
					last: directed_rows[r].exp_last, status: directed_rows[r].exp_status};
				if (n_words != int'(directed_rows[r].n_words) ||
						(n_words > 0 && first_word !== typed_word)) begin
					$display("directed row %0d: %0d words predicted, %0d in table",
						r, n_words, directed_rows[r].n_words);
					note_failure("directed row", typed_word, first_word);
				end
			end
		end

		// Random traffic in stretches: mixed, draining and refilling, so the
		// stack swings between empty and full.
		free_pct = 50;
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 40 == 0) begin
				case ($urandom_range(0, 2))
					0: free_pct = 50;
					1: free_pct = 15;
					default: free_pct = 90;
				endcase
				case ($urandom_range(0, 2))
					0: idle_pct = 0;
					1: idle_pct = 10;
					default: idle_pct = 30;
				endcase
			end
			if (i == PRESSURE_AT) begin
				// keep offering back to back while the receiver holds off
				free_pct     = 40;
				idle_pct     = 0;
				hold_pending = 1'b1;
			end
			if (i >= RANDOM_ITEMS - TAIL_ITEMS)
				quiet_tail = 1'b1;

			if ($urandom_range(0, 99) < free_pct) begin
				cmd   = CMD_FREE;
				count = 7'($urandom_range(0, 127));
				// mostly hand back a page that is really out; else any index
				if (held_pages.size() > 0 && $urandom_range(0, 99) < 85) begin
					pick  = $urandom_range(0, held_pages.size() - 1);
					index = held_pages[pick];
				end else
					index = 7'($urandom_range(0, 127));
			end else begin
				cmd   = CMD_ALLOC;
				index = 7'($urandom_range(0, 127));
				pick  = $urandom_range(0, 99);
				if (pick < 5)
					count = '0;
				else if (pick < 80)
					count = 7'($urandom_range(1, 8));
				else if (pick < 92)
					count = 7'($urandom_range(9, MAX_BATCH));
				else
					count = 7'($urandom_range(MAX_BATCH + 1, 127));
			end
			send_word(cmd, count, index, n_words, first_word);
		end
		req_if.valid <= 1'b0;

		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d allocates and %0d frees, %0d response words checked",
			alloc_seen, free_seen, words_seen);
		$display("%0d nothing-granted words, %0d rejected frees, %0d long receiver hold-offs, %0d failures",
			none_seen, reject_seen, holds_done, fail_count);
		if (fail_count == 0 && pending_words.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

FILE: files.f
+incdir+hdl
hdl/pffla_pkg.sv
hdl/pffla_if.sv
hdl/pffla_front.sv
hdl/pffla_queue.sv
hdl/pffla_back.sv
hdl/page_frame_free_list_allocator.sv
test/tb_top.sv
